// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the checker files of the resampler.
// Depends on nothing; every macro expands to one labeled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while the active-low reset is asserted.
`define LIR_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("%m: property failed");

// Next-cycle implication, disabled while the active-low reset is asserted.
`define LIR_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("%m: property failed");

`endif

// ----- rtl/lir_pkg.sv -----
// Package of the linear-interpolation resampler: widths, limits, transaction types.
// Depends on nothing; imported by every module of the block.
`default_nettype none

package lir_pkg;

  localparam int unsigned SAMPLE_W        = 16;
  localparam int unsigned RUN_W           = 17;
  localparam int unsigned RATE_W          = 18;
  localparam int unsigned POS_W           = 34;
  localparam int unsigned MAX_RUN_SAMPLES = 65536;
  localparam int unsigned MAX_UPSAMPLE    = 8;
  localparam int unsigned CNT_W           = $clog2(MAX_UPSAMPLE + 1);
  localparam int unsigned DIV_W           = POS_W;
  localparam int unsigned DIV_STEP_W      = $clog2(DIV_W + 1);
  localparam int unsigned ACC_W           = SAMPLE_W + RATE_W + 1;
  localparam int unsigned QUEUE_DEPTH     = 2;
  localparam int unsigned QPTR_W          = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W          = $clog2(QUEUE_DEPTH + 1);

  localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(48000);
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

  typedef enum logic {
    REG_SOURCE_RATE = 1'b0,
    REG_TARGET_RATE = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic                start;
    logic [DIV_W-1:0]    dividend;
    logic [RATE_W-1:0]   divisor;
  } div_req_t;

  typedef struct packed {
    logic                done;
    logic [DIV_W-1:0]    quotient;
    logic [RATE_W-1:0]   remainder;
  } div_rsp_t;

  // One classified input item, as handed from the front end to the back end.
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] prev_sample;
    logic signed [SAMPLE_W-1:0] sample;
    logic [POS_W-1:0]           start_pos;
    logic [POS_W-1:0]           left_pos;
    logic [CNT_W-1:0]           span1_cnt;
    logic [CNT_W-1:0]           span2_cnt;
    logic                       cut;
  } entry_t;

  // A rate of zero behaves as a rate of one.
  function automatic logic [RATE_W-1:0] eff_rate(input logic [RATE_W-1:0] rate);
    eff_rate = (rate == '0) ? RATE_W'(1) : rate;
  endfunction

  // Number of outputs kept in one span, limited to MAX_UPSAMPLE.
  function automatic logic [CNT_W-1:0] cap_count(input logic [DIV_W:0] m);
    cap_count = (m > (DIV_W+1)'(MAX_UPSAMPLE)) ? CNT_W'(MAX_UPSAMPLE) : m[CNT_W-1:0];
  endfunction

  function automatic logic over_limit(input logic [DIV_W:0] m);
    over_limit = (m > (DIV_W+1)'(MAX_UPSAMPLE));
  endfunction

endpackage

`default_nettype wire

// ----- rtl/lir_div.sv -----
// Serial restoring divider, one quotient bit per cycle, unsigned operands.
// Depends on lir_pkg for widths and the request/response structs.
`default_nettype none

module lir_div import lir_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic [DIV_W-1:0]      quo_q, quo_d;
  logic [RATE_W-1:0]     rem_q, rem_d;
  logic [RATE_W-1:0]     dvs_q, dvs_d;
  logic [DIV_STEP_W-1:0] step_q, step_d;
  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [RATE_W:0]       trial;
  logic [RATE_W:0]       diff;

  always_comb begin
    trial  = {rem_q, quo_q[DIV_W-1]};
    diff   = trial - {1'b0, dvs_q};
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    step_d = step_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      quo_d  = req_i.dividend;
      rem_d  = '0;
      dvs_d  = req_i.divisor;
      step_d = DIV_STEP_W'(DIV_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = diff[RATE_W-1:0];
        quo_d = {quo_q[DIV_W-2:0], 1'b1};
      end else begin
        rem_d = trial[RATE_W-1:0];
        quo_d = {quo_q[DIV_W-2:0], 1'b0};
      end
      step_d = step_q - 1'b1;
      if (step_q == DIV_STEP_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = quo_q;
  assign rsp_o.remainder = rem_q;

endmodule

`default_nettype wire

// ----- rtl/lir_queue.sv -----
// Short queue of classified items between the front end and the back end.
// Depends on lir_pkg for the entry type and the queue depth.
`default_nettype none

module lir_queue import lir_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t entry_i,
  output logic   full_o,
  input  logic   pop_i,
  output entry_t entry_o,
  output logic   empty_o
);

  entry_t            slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;
  logic              do_push;
  logic              do_pop;

  assign full_o  = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign entry_o = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/lir_front.sv -----
// Front end: accepts input samples, tracks run positions and sizes both output spans.
// Depends on lir_pkg; drives one lir_div instance and pushes into lir_queue.
`default_nettype none

module lir_front import lir_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic signed [SAMPLE_W-1:0] pcm_sample_i,
  input  logic [RUN_W-1:0]           run_length_i,
  input  logic [RATE_W-1:0]          source_rate_i,
  input  logic [RATE_W-1:0]          target_rate_i,
  output div_req_t                   div_req_o,
  input  div_rsp_t                   div_rsp_i,
  output logic                       push_o,
  output entry_t                     entry_o,
  input  logic                       full_i
);

  typedef enum logic [7:0] {
    F_IDLE = 8'b0000_0001,
    F_PREP = 8'b0000_0010,
    F_CHK  = 8'b0000_0100,
    F_D2   = 8'b0000_1000,
    F_D1   = 8'b0001_0000,
    F_S2   = 8'b0010_0000,
    F_D3   = 8'b0100_0000,
    F_PUSH = 8'b1000_0000
  } front_state_e;

  front_state_e state_q, state_d;

  // Run state.
  logic signed [SAMPLE_W-1:0] prev_q, prev_d;
  logic [RUN_W-1:0]           seen_q, seen_d;
  logic [POS_W-1:0]           pos_q, pos_d;
  logic [POS_W-1:0]           kto_q, kto_d;

  // Per-item working registers.
  logic signed [SAMPLE_W-1:0] sample_q, sample_d;
  logic [RUN_W-1:0]           nrun_q, nrun_d;
  logic [POS_W-1:0]           nto_q, nto_d;
  logic                       last_q, last_d;
  logic [DIV_W-1:0]           q2_q, q2_d;
  logic [RATE_W-1:0]          r2_q, r2_d;
  logic [POS_W-1:0]           posw_q, posw_d;
  logic [CNT_W-1:0]           span1_q, span1_d;
  logic [CNT_W-1:0]           span2_q, span2_d;
  logic                       cut_q, cut_d;

  logic [RATE_W-1:0]       from_eff;
  logic [RATE_W-1:0]       to_eff;
  logic [RUN_W-1:0]        run_sat;
  logic [RUN_W+RATE_W-1:0] nto_full;
  logic [RUN_W:0]          seen_next;
  logic                    span1_on;
  logic                    r1_nz;
  logic [DIV_W:0]          c1;
  logic [DIV_W:0]          m1;
  logic                    take_c1;
  logic [POS_W-1:0]        pos_c1;
  logic [POS_W-1:0]        pos_c2;
  logic                    has_results;

  assign from_eff  = eff_rate(source_rate_i);
  assign to_eff    = eff_rate(target_rate_i);
  assign nto_full  = nrun_q * to_eff;
  assign seen_next = {1'b0, seen_q} + 1'b1;
  assign span1_on  = (seen_q != '0) && (pos_q < kto_q) && (pos_q <= nto_q);
  assign in_stall_o = (state_q != F_IDLE);

  always_comb begin
    if (run_length_i == '0) begin
      run_sat = RUN_W'(1);
    end else if (run_length_i > RUN_W'(MAX_RUN_SAMPLES)) begin
      run_sat = RUN_W'(MAX_RUN_SAMPLES);
    end else begin
      run_sat = run_length_i;
    end
  end

  // The first span ends either at the bound of the current sample or at the end of the
  // run; the position advance comes from the division remainders, not a product.
  assign r1_nz   = (div_rsp_i.remainder != '0);
  assign c1      = {1'b0, div_rsp_i.quotient} + {{DIV_W{1'b0}}, r1_nz};
  assign take_c1 = (c1 <= {1'b0, q2_q});
  assign m1      = take_c1 ? c1 : {1'b0, q2_q};
  assign pos_c1  = kto_q + POS_W'(r1_nz ? from_eff - div_rsp_i.remainder : '0);
  assign pos_c2  = nto_q - POS_W'(r2_q);
  assign has_results = (span1_q != '0) || (span2_q != '0);

  always_comb begin
    entry_o.prev_sample = prev_q;
    entry_o.sample      = sample_q;
    entry_o.start_pos   = pos_q;
    entry_o.left_pos    = (kto_q >= POS_W'(to_eff)) ? kto_q - POS_W'(to_eff) : '0;
    entry_o.span1_cnt   = span1_q;
    entry_o.span2_cnt   = span2_q;
    entry_o.cut         = cut_q;
  end

  always_comb begin
    state_d   = state_q;
    prev_d    = prev_q;
    seen_d    = seen_q;
    pos_d     = pos_q;
    kto_d     = kto_q;
    sample_d  = sample_q;
    nrun_d    = nrun_q;
    nto_d     = nto_q;
    last_d    = last_q;
    q2_d      = q2_q;
    r2_d      = r2_q;
    posw_d    = posw_q;
    span1_d   = span1_q;
    span2_d   = span2_q;
    cut_d     = cut_q;
    div_req_o = '0;
    push_o    = 1'b0;
    unique case (state_q)
      F_IDLE: begin
        if (in_valid_i) begin
          sample_d = pcm_sample_i;
          nrun_d   = run_sat;
          state_d  = F_PREP;
        end
      end
      F_PREP: begin
        nto_d   = nto_full[POS_W-1:0];
        last_d  = (seen_next >= {1'b0, nrun_q});
        state_d = F_CHK;
      end
      F_CHK: begin
        posw_d  = pos_q;
        span1_d = '0;
        span2_d = '0;
        cut_d   = 1'b0;
        if (span1_on) begin
          div_req_o.start    = 1'b1;
          div_req_o.dividend = nto_q - pos_q;
          div_req_o.divisor  = from_eff;
          state_d            = F_D2;
        end else begin
          state_d = F_S2;
        end
      end
      F_D2: begin
        if (div_rsp_i.done) begin
          q2_d               = div_rsp_i.quotient;
          r2_d               = div_rsp_i.remainder;
          div_req_o.start    = 1'b1;
          div_req_o.dividend = kto_q - pos_q;
          div_req_o.divisor  = from_eff;
          state_d            = F_D1;
        end
      end
      F_D1: begin
        if (div_rsp_i.done) begin
          posw_d  = take_c1 ? pos_c1 : pos_c2;
          span1_d = cap_count(m1);
          cut_d   = over_limit(m1);
          state_d = F_S2;
        end
      end
      F_S2: begin
        if (last_q && (posw_q <= nto_q)) begin
          div_req_o.start    = 1'b1;
          div_req_o.dividend = nto_q - posw_q;
          div_req_o.divisor  = from_eff;
          state_d            = F_D3;
        end else begin
          state_d = F_PUSH;
        end
      end
      F_D3: begin
        if (div_rsp_i.done) begin
          span2_d = cap_count({1'b0, div_rsp_i.quotient});
          cut_d   = cut_q | over_limit({1'b0, div_rsp_i.quotient});
          state_d = F_PUSH;
        end
      end
      F_PUSH: begin
        if (!has_results || !full_i) begin
          push_o = has_results;
          prev_d = sample_q;
          if (last_q) begin
            seen_d = '0;
            pos_d  = '0;
            kto_d  = '0;
          end else begin
            seen_d = seen_next[RUN_W-1:0];
            pos_d  = posw_q;
            kto_d  = kto_q + POS_W'(to_eff);
          end
          state_d = F_IDLE;
        end
      end
      default: begin
        state_d = F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      prev_q  <= '0;
      seen_q  <= '0;
      pos_q   <= '0;
      kto_q   <= '0;
    end else begin
      state_q <= state_d;
      prev_q  <= prev_d;
      seen_q  <= seen_d;
      pos_q   <= pos_d;
      kto_q   <= kto_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sample_q <= sample_d;
    nrun_q   <= nrun_d;
    nto_q    <= nto_d;
    last_q   <= last_d;
    q2_q     <= q2_d;
    r2_q     <= r2_d;
    posw_q   <= posw_d;
    span1_q  <= span1_d;
    span2_q  <= span2_d;
    cut_q    <= cut_d;
  end

endmodule

`default_nettype wire

// ----- rtl/lir_back.sv -----
// Back end: turns queued items into interpolated samples and drives the result register.
// Depends on lir_pkg; pops lir_queue and drives its own lir_div instance.
`default_nettype none

module lir_back import lir_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  output logic                       pop_o,
  input  entry_t                     entry_i,
  input  logic                       empty_i,
  output div_req_t                   div_req_o,
  input  div_rsp_t                   div_rsp_i,
  input  logic [RATE_W-1:0]          source_rate_i,
  input  logic [RATE_W-1:0]          target_rate_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic signed [SAMPLE_W-1:0] out_sample_o,
  output logic                       out_group_end_o,
  output logic                       out_group_cut_o
);

  typedef enum logic [6:0] {
    B_IDLE = 7'b000_0001,
    B_WGT  = 7'b000_0010,
    B_MUL0 = 7'b000_0100,
    B_MUL1 = 7'b000_1000,
    B_ABS  = 7'b001_0000,
    B_DIV  = 7'b010_0000,
    B_OUT  = 7'b100_0000
  } back_state_e;

  back_state_e state_q, state_d;

  entry_t                     ent_q, ent_d;
  logic [POS_W-1:0]           p_q, p_d;
  logic [CNT_W-1:0]           cnt1_q, cnt1_d;
  logic [CNT_W-1:0]           cnt2_q, cnt2_d;
  logic [RATE_W-1:0]          w0_q, w0_d;
  logic [RATE_W-1:0]          w1_q, w1_d;
  logic signed [ACC_W-1:0]    acc_q, acc_d;
  logic                       neg_q, neg_d;
  logic signed [SAMPLE_W-1:0] res_q, res_d;

  logic                       out_valid_q, out_valid_d;
  logic signed [SAMPLE_W-1:0] out_sample_q, out_sample_d;
  logic                       out_end_q, out_end_d;
  logic                       out_cut_q, out_cut_d;

  logic [RATE_W-1:0]          from_eff;
  logic [RATE_W-1:0]          to_eff;
  logic [POS_W-1:0]           span_off;
  logic [POS_W-1:0]           rem_full;
  logic [RATE_W-1:0]          rem_w;
  logic signed [SAMPLE_W-1:0] mul_a;
  logic [RATE_W-1:0]          mul_b;
  logic signed [ACC_W-1:0]    prod;
  logic [ACC_W-1:0]           acc_mag;
  logic [DIV_W-1:0]           quo;
  logic [SAMPLE_W-1:0]        quo_lo;
  logic                       slot_free;
  logic                       in_span1;
  logic                       last_result;

  assign from_eff = eff_rate(source_rate_i);
  assign to_eff   = eff_rate(target_rate_i);

  // Distance of the output position from its left neighbour, clamped to [0, to].
  assign span_off = p_q - ent_q.left_pos;
  assign rem_full = (p_q > ent_q.left_pos) ? span_off : '0;
  assign rem_w    = (rem_full > POS_W'(to_eff)) ? to_eff : rem_full[RATE_W-1:0];

  // One shared multiplier; the two weighted terms are added in the states B_MUL0 and B_MUL1.
  assign mul_a = (state_q == B_MUL0) ? ent_q.prev_sample : ent_q.sample;
  assign mul_b = (state_q == B_MUL0) ? w0_q : w1_q;
  assign prod  = mul_a * $signed({1'b0, mul_b});

  assign acc_mag = acc_q[ACC_W-1] ? ACC_W'(-acc_q) : acc_q;
  assign quo     = div_rsp_i.quotient;
  assign quo_lo  = quo[SAMPLE_W-1:0];

  assign slot_free   = !out_valid_q || !out_stall_i;
  assign in_span1    = (cnt1_q != '0);
  assign last_result = (({1'b0, cnt1_q} + {1'b0, cnt2_q}) == (CNT_W+1)'(1));

  always_comb begin
    state_d      = state_q;
    ent_d        = ent_q;
    p_d          = p_q;
    cnt1_d       = cnt1_q;
    cnt2_d       = cnt2_q;
    w0_d         = w0_q;
    w1_d         = w1_q;
    acc_d        = acc_q;
    neg_d        = neg_q;
    res_d        = res_q;
    out_sample_d = out_sample_q;
    out_end_d    = out_end_q;
    out_cut_d    = out_cut_q;
    out_valid_d  = out_valid_q && out_stall_i;
    div_req_o    = '0;
    pop_o        = 1'b0;
    unique case (state_q)
      B_IDLE: begin
        if (!empty_i) begin
          pop_o   = 1'b1;
          ent_d   = entry_i;
          p_d     = entry_i.start_pos;
          cnt1_d  = entry_i.span1_cnt;
          cnt2_d  = entry_i.span2_cnt;
          state_d = (entry_i.span1_cnt != '0) ? B_WGT : B_OUT;
        end
      end
      B_WGT: begin
        w1_d    = rem_w;
        w0_d    = to_eff - rem_w;
        state_d = B_MUL0;
      end
      B_MUL0: begin
        acc_d   = prod;
        state_d = B_MUL1;
      end
      B_MUL1: begin
        acc_d   = acc_q + prod;
        state_d = B_ABS;
      end
      B_ABS: begin
        div_req_o.start    = 1'b1;
        div_req_o.dividend = acc_mag[DIV_W-1:0];
        div_req_o.divisor  = to_eff;
        neg_d              = acc_q[ACC_W-1];
        state_d            = B_DIV;
      end
      B_DIV: begin
        if (div_rsp_i.done) begin
          // Quotient of the magnitude, so the sign restores truncation toward zero.
          if (neg_q) begin
            res_d = (quo > DIV_W'(SAMPLE_MAX) + 1'b1) ? SAMPLE_MIN : $signed(-quo_lo);
          end else begin
            res_d = (quo > DIV_W'(SAMPLE_MAX)) ? SAMPLE_MAX : $signed(quo_lo);
          end
          state_d = B_OUT;
        end
      end
      B_OUT: begin
        if (slot_free) begin
          out_valid_d  = 1'b1;
          out_sample_d = in_span1 ? res_q : ent_q.sample;
          out_end_d    = last_result;
          out_cut_d    = ent_q.cut;
          if (in_span1) begin
            cnt1_d = cnt1_q - 1'b1;
            if (cnt1_q != CNT_W'(1)) begin
              p_d     = p_q + POS_W'(from_eff);
              state_d = B_WGT;
            end else if (cnt2_q != '0) begin
              state_d = B_OUT;
            end else begin
              state_d = B_IDLE;
            end
          end else begin
            cnt2_d  = cnt2_q - 1'b1;
            state_d = (cnt2_q != CNT_W'(1)) ? B_OUT : B_IDLE;
          end
        end
      end
      default: begin
        state_d = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      out_valid_q <= 1'b0;
      cnt1_q      <= '0;
      cnt2_q      <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      cnt1_q      <= cnt1_d;
      cnt2_q      <= cnt2_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q        <= ent_d;
    p_q          <= p_d;
    w0_q         <= w0_d;
    w1_q         <= w1_d;
    acc_q        <= acc_d;
    neg_q        <= neg_d;
    res_q        <= res_d;
    out_sample_q <= out_sample_d;
    out_end_q    <= out_end_d;
    out_cut_q    <= out_cut_d;
  end

  assign out_valid_o     = out_valid_q;
  assign out_sample_o    = out_sample_q;
  assign out_group_end_o = out_end_q;
  assign out_group_cut_o = out_cut_q;

endmodule

`default_nettype wire

// ----- rtl/linear_interp_resampler.sv -----
// Top level of the linear-interpolation sample-rate converter for 16-bit mono PCM.
// Depends on lir_pkg, lir_div, lir_queue, lir_front and lir_back.
//
// Usage: each input transaction (in_valid_i high, in_stall_o low at a clock edge) carries
// one signed sample and the length of its run. Output transactions (out_valid_o high,
// out_stall_i low) carry the interpolated samples that the input makes due, with
// out_group_end_o on the last one of that input and out_group_cut_o on all of them when
// a span held more than the allowed number of outputs. An input may cause no output.
// The user must write the rates on the cfg_we_i/cfg_index_i/cfg_data_i port only while
// the block is idle, which the block does not enforce; a rate of zero acts as one.
// The front end sizes the spans with a bit-serial divider, and an item needs no
// division or up to three. Each interpolated output of the back end waits on its own
// serial division by the target rate; an output that repeats the run's last sample
// needs no division. A two-entry queue lets the front end classify the next item
// while the back end is still emitting.
// Reset clears the rates to 48000 and the run state to zero; the queue and the result
// register come up empty. A stalled receiver holds the result register, then the back
// end, then the queue and finally the input through in_stall_o; nothing is dropped.
`default_nettype none

module linear_interp_resampler import lir_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic signed [SAMPLE_W-1:0] pcm_sample_i,
  input  logic [RUN_W-1:0]           run_length_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic signed [SAMPLE_W-1:0] out_sample_o,
  output logic                       out_group_end_o,
  output logic                       out_group_cut_o,
  input  logic                       cfg_we_i,
  input  logic                       cfg_index_i,
  input  logic [RATE_W-1:0]          cfg_data_i
);

  // Rate registers. The back end reads them live, which is safe only if the user
  // changes them while no transaction is in flight; the block does not enforce this.
  logic [RATE_W-1:0] source_rate_q, source_rate_d;
  logic [RATE_W-1:0] target_rate_q, target_rate_d;

  div_req_t front_div_req;
  div_rsp_t front_div_rsp;
  div_req_t back_div_req;
  div_rsp_t back_div_rsp;
  logic     push;
  entry_t   push_entry;
  logic     queue_full;
  logic     pop;
  entry_t   head_entry;
  logic     queue_empty;

  always_comb begin
    source_rate_d = source_rate_q;
    target_rate_d = target_rate_q;
    if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_SOURCE_RATE: source_rate_d = cfg_data_i;
        REG_TARGET_RATE: target_rate_d = cfg_data_i;
        default: begin
          source_rate_d = source_rate_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      source_rate_q <= RATE_RESET;
      target_rate_q <= RATE_RESET;
    end else begin
      source_rate_q <= source_rate_d;
      target_rate_q <= target_rate_d;
    end
  end

  // Front end: input handshake, run bookkeeping and span sizing.
  lir_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .pcm_sample_i  (pcm_sample_i),
    .run_length_i  (run_length_i),
    .source_rate_i (source_rate_q),
    .target_rate_i (target_rate_q),
    .div_req_o     (front_div_req),
    .div_rsp_i     (front_div_rsp),
    .push_o        (push),
    .entry_o       (push_entry),
    .full_i        (queue_full)
  );

  lir_div u_front_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (front_div_req),
    .rsp_o  (front_div_rsp)
  );

  lir_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (queue_full),
    .pop_i   (pop),
    .entry_o (head_entry),
    .empty_o (queue_empty)
  );

  // Back end: interpolation, division by the target rate and the result register.
  lir_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .pop_o           (pop),
    .entry_i         (head_entry),
    .empty_i         (queue_empty),
    .div_req_o       (back_div_req),
    .div_rsp_i       (back_div_rsp),
    .source_rate_i   (source_rate_q),
    .target_rate_i   (target_rate_q),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_sample_o    (out_sample_o),
    .out_group_end_o (out_group_end_o),
    .out_group_cut_o (out_group_cut_o)
  );

  lir_div u_back_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (back_div_req),
    .rsp_o  (back_div_rsp)
  );

endmodule

`default_nettype wire

// ----- rtl/lir_checker.sv -----
// Port-level checker of the resampler, attached to the top level by a bind.
// Depends on lir_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module lir_checker import lir_pkg::*; (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_stall_o,
  input logic                       out_valid_o,
  input logic                       out_stall_i,
  input logic signed [SAMPLE_W-1:0] out_sample_o,
  input logic                       out_group_end_o,
  input logic                       out_group_cut_o
);

  logic                  in_xact;
  logic                  out_held;
  logic [SAMPLE_W+1:0]   out_payload;

  assign in_xact     = in_valid_i && !in_stall_o;
  assign out_held    = out_valid_o && out_stall_i;
  assign out_payload = {out_sample_o, out_group_end_o, out_group_cut_o};

  // A stalled result stays offered and unchanged.
  `LIR_ASSERT_NXT(a_out_hold_valid, clk_i, rst_ni, out_held, out_valid_o)
  `LIR_ASSERT_NXT(a_out_hold_data, clk_i, rst_ni, out_held, $stable(out_payload))
  // The front end works on one item at a time, so it stalls right after taking one.
  `LIR_ASSERT_NXT(a_in_one_at_a_time, clk_i, rst_ni, in_xact, in_stall_o)
  // Leaving reset, no result is offered and the input side is open.
  `LIR_ASSERT_IMP(a_reset_empty, clk_i, rst_ni, $rose(rst_ni), !out_valid_o && !in_stall_o)

endmodule

bind linear_interp_resampler lir_checker u_lir_checker (.*);

`default_nettype wire
